// File: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication failed");

// Next-cycle implication, disabled while rst is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// File: design/iwc_pkg.sv
// Types, codes and constants of the image window convolution block.
package iwc_pkg;

  localparam int DEF_MAX_WIDTH = 1024;
  localparam int MIN_WIDTH     = 5;
  localparam logic [10:0] WIDTH_RESET = 11'd512;

  // register indexes on the configuration port
  localparam logic REG_IMAGE_WIDTH = 1'b0;
  localparam logic REG_FILTER_MODE = 1'b1;

  // filter modes (code 3 behaves as gaussian)
  localparam logic [1:0] MODE_GAUSS   = 2'd0;
  localparam logic [1:0] MODE_SOBEL_X = 2'd1;
  localparam logic [1:0] MODE_SOBEL_Y = 2'd2;

  // input item kinds
  localparam logic KIND_PIXEL = 1'b0;

  // floor(x / 159) = (x * 52759) >> 23 for every x up to 159 * 255
  localparam logic [15:0] DIV159_MUL   = 16'd52759;
  localparam int          DIV159_SHIFT = 23;

  localparam logic [3:0] GAUSS_K [5][5] = '{
    '{4'd2, 4'd4,  4'd5,  4'd4,  4'd2},
    '{4'd4, 4'd9,  4'd12, 4'd9,  4'd4},
    '{4'd5, 4'd12, 4'd15, 4'd12, 4'd5},
    '{4'd4, 4'd9,  4'd12, 4'd9,  4'd4},
    '{4'd2, 4'd4,  4'd5,  4'd4,  4'd2}
  };

  localparam logic signed [2:0] SOBEL_X [3][3] = '{
    '{-3'sd1, 3'sd0, 3'sd1},
    '{-3'sd2, 3'sd0, 3'sd2},
    '{-3'sd1, 3'sd0, 3'sd1}
  };

  localparam logic signed [2:0] SOBEL_Y [3][3] = '{
    '{ 3'sd1,  3'sd2,  3'sd1},
    '{ 3'sd0,  3'sd0,  3'sd0},
    '{-3'sd1, -3'sd2, -3'sd1}
  };

  // 5x5 window, [row][col], row 0 is two rows above the centre
  typedef logic [4:0][4:0][7:0] win_t;

  // one column of history: slot k is the pixel k+1 rows back
  typedef logic [3:0][7:0] line_word_t;

  typedef struct packed {
    logic valid;
    logic last;
  } win_ctl_t;

endpackage

// File: design/iwc_line_store.sv
// Four line stores held as one memory word per image column.
module iwc_line_store #(
  parameter int MAX_WIDTH = iwc_pkg::DEF_MAX_WIDTH
) (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  output iwc_pkg::line_word_t          rd_data,
  input  logic                         wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  input  iwc_pkg::line_word_t          wr_data
);

  iwc_pkg::line_word_t mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/iwc_filter.sv
// Filter datapath: gaussian 5x5 / sobel 3x3 sums, scaling and output register.
module iwc_filter (
  input  logic              clk,
  input  logic              rst,
  input  iwc_pkg::win_ctl_t ctl,
  output logic              ready,
  input  iwc_pkg::win_t     taps,
  input  logic [1:0]        mode,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        pixel_out,
  output logic              frame_last
);

  // stage c: row sums and sobel sum
  logic                     c_valid;
  logic                     c_last;
  logic                     c_gauss;
  logic [4:0][13:0]         c_row;
  logic signed [10:0]       c_sob;
  // stage d: gaussian total and clamped sobel
  logic                     d_valid;
  logic                     d_last;
  logic                     d_gauss;
  logic [15:0]              d_gsum;
  logic [7:0]               d_sob;

  logic                     c_ready;
  logic                     d_ready;
  logic                     o_ready;
  logic                     is_gauss;
  logic                     use_y;
  logic [4:0][13:0]         row_sum;
  logic signed [10:0]       sob_sum;
  logic [15:0]              gsum;
  logic [7:0]               sob_clamp;
  logic [31:0]              prod;

  assign o_ready = !out_valid || out_ready;
  assign d_ready = !d_valid || o_ready;
  assign c_ready = !c_valid || d_ready;
  assign ready   = c_ready;

  assign is_gauss = !(mode == iwc_pkg::MODE_SOBEL_X || mode == iwc_pkg::MODE_SOBEL_Y);
  assign use_y    = (mode == iwc_pkg::MODE_SOBEL_Y);

  always_comb begin
    logic [13:0]        acc;
    logic signed [10:0] kk;
    logic signed [10:0] sacc;
    for (int i = 0; i < 5; i++) begin
      acc = '0;
      for (int j = 0; j < 5; j++) begin
        acc = acc + 14'(iwc_pkg::GAUSS_K[i][j]) * 14'(taps[i][j]);
      end
      row_sum[i] = acc;
    end
    sacc = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        kk = 11'(use_y ? iwc_pkg::SOBEL_Y[i][j] : iwc_pkg::SOBEL_X[i][j]);
        sacc = sacc + kk * $signed({3'b000, taps[i+1][j+1]});
      end
    end
    sob_sum = sacc;
  end

  always_comb begin
    gsum = '0;
    for (int i = 0; i < 5; i++) begin
      gsum = gsum + 16'(c_row[i]);
    end
    if (c_sob < 11'sd0) begin
      sob_clamp = 8'd0;
    end else if (c_sob > 11'sd255) begin
      sob_clamp = 8'd255;
    end else begin
      sob_clamp = c_sob[7:0];
    end
  end

  assign prod = 32'(d_gsum) * 32'(iwc_pkg::DIV159_MUL);

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid   <= 1'b0;
      d_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (c_ready) begin
        c_valid <= ctl.valid;
      end
      if (d_ready) begin
        d_valid <= c_valid;
      end
      if (o_ready) begin
        out_valid <= d_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready && ctl.valid) begin
      c_row   <= row_sum;
      c_sob   <= sob_sum;
      c_gauss <= is_gauss;
      c_last  <= ctl.last;
    end
    if (d_ready && c_valid) begin
      d_gsum  <= gsum;
      d_sob   <= sob_clamp;
      d_gauss <= c_gauss;
      d_last  <= c_last;
    end
    if (o_ready && d_valid) begin
      pixel_out  <= d_gauss ? prod[iwc_pkg::DIV159_SHIFT+7 -: 8] : d_sob;
      frame_last <= d_last;
    end
  end

endmodule

// File: design/image_window_convolution.sv
// Top level: streaming 5x5 gaussian / 3x3 sobel filter over square grey images.
//
// Pixels of a W x W frame (W = image_width, held to 5..MAX_WIDTH) enter in
// raster order, one transaction per clock unless stalled, and the block returns
// one filtered pixel per image position in raster order. Taps outside the image
// read as zero. filter_mode 0 (and 3) gives the 5x5 gaussian sum divided by
// 159, truncated; modes 1 and 2 give the centred sobel X / Y sums clamped to
// 0..255. The result for position p leaves with the input transaction at
// p + 2W + 2, so the first 2W + 2 inputs of a frame give nothing and 2W + 2
// flush transactions (kind = 1) drain the tail; frame_last marks the final
// output, after which the next input starts a new frame. A flush inside the
// image counts as a zero pixel; a pixel past the image end counts as a flush.
// Rate: one transaction per clock in and out unless stalled. Input to output:
// line store read, window shift, row sums, total, divide-by-159 multiply into
// the output register. Writing image_width restarts the frame. The user must
// write configuration only while the block is idle; the block does not enforce
// it. No clearing pass after reset: stale history is never used, because the
// tap mask blocks every row and column outside the current frame.
module image_window_convolution #(
  parameter int MAX_WIDTH = iwc_pkg::DEF_MAX_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [7:0]  pixel_in,
  // output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  pixel_out,
  output logic        frame_last,
  // configuration port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH) + 1;   // holds up to W + 2 rows

  // configuration registers
  logic [10:0]   image_width;
  logic [1:0]    filter_mode;
  logic [CW-1:0] w_eff;

  // position counters: next input and next output position
  logic [CW-1:0] in_row;
  logic [CW-1:0] in_col;
  logic [CW-1:0] out_row;
  logic [CW-1:0] out_col;

  // stage a: accepted transaction, line store read in flight
  logic          a_valid;
  logic          a_emit;
  logic          a_last;
  logic [7:0]    a_pix;
  logic [AW-1:0] a_col;
  logic [4:0]    a_rowok;
  logic [4:0]    a_colok;

  // stage b: window holds the taps of the output position
  logic          b_valid;
  logic          b_last;
  logic [4:0]    b_rowok;
  logic [4:0]    b_colok;
  iwc_pkg::win_t win;          // [row age][column age], age 0 is newest

  iwc_pkg::line_word_t rd_word;
  iwc_pkg::line_word_t wr_word;
  iwc_pkg::win_t       taps;
  iwc_pkg::win_ctl_t   f_ctl;

  logic          accept;
  logic          a_adv;
  logic          b_free;
  logic          f_ready;
  logic          emit;
  logic          out_end;
  logic          in_col_end;
  logic          out_col_end;
  logic [7:0]    pix_v;
  logic [4:0]    rowok;
  logic [4:0]    colok;

  // effective width, clamped to the supported range
  always_comb begin
    if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else if (32'(image_width) < 32'(iwc_pkg::MIN_WIDTH)) begin
      w_eff = CW'(iwc_pkg::MIN_WIDTH);
    end else begin
      w_eff = CW'(image_width);
    end
  end

  // handshake: stage a drains into b, b into the filter pipe
  assign b_free   = !b_valid || f_ready;
  assign a_adv    = a_valid && b_free;
  assign in_ready = !a_valid || b_free;
  assign accept   = in_valid && in_ready;

  // pixels past the image and flushes inside the image both store zero
  assign pix_v = (kind == iwc_pkg::KIND_PIXEL && in_row < w_eff) ? pixel_in : 8'd0;

  // output for position p rides on input position p + 2W + 2
  assign emit        = (in_row > CW'(2)) || (in_row == CW'(2) && in_col >= CW'(2));
  assign in_col_end  = (in_col == w_eff - CW'(1));
  assign out_col_end = (out_col == w_eff - CW'(1));
  assign out_end     = emit && out_col_end && (out_row == w_eff - CW'(1));

  // which window rows / columns lie inside the image, index = offset + 2
  assign rowok = {out_row < w_eff - CW'(2), out_row < w_eff - CW'(1), 1'b1,
                  out_row >= CW'(1), out_row >= CW'(2)};
  assign colok = {out_col < w_eff - CW'(2), out_col < w_eff - CW'(1), 1'b1,
                  out_col >= CW'(1), out_col >= CW'(2)};

  // configuration and position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= iwc_pkg::WIDTH_RESET;
      filter_mode <= iwc_pkg::MODE_GAUSS;
      in_row      <= '0;
      in_col      <= '0;
      out_row     <= '0;
      out_col     <= '0;
    end else if (cfg_we && cfg_index == iwc_pkg::REG_IMAGE_WIDTH) begin
      image_width <= cfg_data;
      in_row      <= '0;
      in_col      <= '0;
      out_row     <= '0;
      out_col     <= '0;
    end else begin
      if (cfg_we && cfg_index == iwc_pkg::REG_FILTER_MODE) begin
        filter_mode <= cfg_data[1:0];
      end
      if (accept) begin
        if (out_end) begin
          // frame done: next transaction starts a fresh frame
          in_row  <= '0;
          in_col  <= '0;
          out_row <= '0;
          out_col <= '0;
        end else begin
          in_col <= in_col_end ? '0 : in_col + CW'(1);
          if (in_col_end) begin
            in_row <= in_row + CW'(1);
          end
          if (emit) begin
            out_col <= out_col_end ? '0 : out_col + CW'(1);
            if (out_col_end) begin
              out_row <= out_row + CW'(1);
            end
          end
        end
      end
    end
  end

  // line stores: read at accept, write the shifted column when a moves on
  assign wr_word = {rd_word[2], rd_word[1], rd_word[0], a_pix};

  iwc_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_lines (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (in_col[AW-1:0]),
    .rd_data (rd_word),
    .wr_en   (a_adv),
    .wr_addr (a_col),
    .wr_data (wr_word)
  );

  // valid bits of stages a and b
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        a_valid <= in_valid;
      end
      if (a_adv) begin
        b_valid <= a_emit;    // items with no output still shift the window
      end else if (f_ready) begin
        b_valid <= 1'b0;
      end
    end
  end

  // stage a / b payload and window shift
  always_ff @(posedge clk) begin
    if (accept) begin
      a_pix   <= pix_v;
      a_col   <= in_col[AW-1:0];
      a_emit  <= emit;
      a_last  <= out_end;
      a_rowok <= rowok;
      a_colok <= colok;
    end
    if (a_adv) begin
      b_last  <= a_last;
      b_rowok <= a_rowok;
      b_colok <= a_colok;
      for (int r = 0; r < 5; r++) begin
        for (int c = 4; c > 0; c--) begin
          win[r][c] <= win[r][c-1];
        end
      end
      win[0][0] <= a_pix;
      win[1][0] <= rd_word[0];
      win[2][0] <= rd_word[1];
      win[3][0] <= rd_word[2];
      win[4][0] <= rd_word[3];
    end
  end

  // map ages to centred offsets and zero taps outside the image
  always_comb begin
    for (int i = 0; i < 5; i++) begin
      for (int j = 0; j < 5; j++) begin
        taps[i][j] = (b_rowok[i] && b_colok[j]) ? win[4-i][4-j] : 8'd0;
      end
    end
  end

  assign f_ctl.valid = b_valid;
  assign f_ctl.last  = b_last;

  iwc_filter u_filter (
    .clk        (clk),
    .rst        (rst),
    .ctl        (f_ctl),
    .ready      (f_ready),
    .taps       (taps),
    .mode       (filter_mode),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_out  (pixel_out),
    .frame_last (frame_last)
  );

endmodule

// File: design/iwc_checker.sv
// Port-level checker for image_window_convolution, bound to the top level.
`include "assert_macros.svh"

module iwc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] pixel_out,
  input logic       frame_last
);

  // a stalled result stays offered
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)

  // a stalled result keeps its payload
  `ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(pixel_out) && $stable(frame_last))

  // reset empties the pipe
  `ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !out_valid)

  // with the output register empty nothing upstream may stall
  `ASSERT_IMPL(a_drain_ready, clk, rst, !out_valid, in_ready)

  // an empty output stays empty unless something entered
  `ASSERT_NEXT(a_no_spurious, clk, rst, !out_valid && !in_valid && $past(!in_valid) && $past(!in_valid, 2) && $past(!in_valid, 3) && $past(!in_valid, 4) && $past(!in_valid, 5), !out_valid)

endmodule

bind image_window_convolution iwc_checker u_iwc_checker (.*);

// File: verif/image_window_convolution_tb.sv
// Self-checking testbench for the image window convolution block.
`timescale 1ns / 100ps

// Sends square grey frames in raster order through the filter and checks every
// output transaction against a line-by-line predictor kept in this file.
//
// Flow:
//   - directed table at minimum width: early items that give no result,
//     sobel saturation at both ends, unused mode code, flush inside the image,
//     pixels past the image end and the frame end marker
//   - random phases: small widths (some written below range), random mode,
//     mostly whole frames with random content, a few flush transactions inside
//     the image, a few pixels in the drain tail and some frames cut short
//   - two short runs at the largest width (written exact and above range);
//     they stop well before the first output of a full-width frame
//
// Idling: the sender idles 9% and the receiver 71% for the first third of the
// random part, then the other way round, then neither side idles.
// Registers are written only after the output queue has drained plus a tail of
// cycles, so the five stage pipe is empty at every write.
module image_window_convolution_tb;

  localparam logic       KIND_FLUSH   = ~iwc_pkg::KIND_PIXEL;
  localparam logic [1:0] MODE_UNUSED  = 2'd3;     // behaves as gaussian
  localparam int         HIST_DEPTH   = 4 * iwc_pkg::DEF_MAX_WIDTH + 8;
  localparam int         BLUR_NORM    = 159;
  localparam int         RANDOM_ITEMS = 1700;
  localparam int         TAIL_CYCLES  = 16;       // idle tail that lets the pipe empty
  localparam int         WIDE_ITEMS   = 32;       // items sent at full width

  localparam int BLUR_WT [5][5] = '{
    '{2, 4,  5,  4,  2},
    '{4, 9,  12, 9,  4},
    '{5, 12, 15, 12, 5},
    '{4, 9,  12, 9,  4},
    '{2, 4,  5,  4,  2}
  };
  localparam int GRAD_X_WT [3][3] = '{'{-1, 0, 1}, '{-2, 0, 2}, '{-1, 0, 1}};
  localparam int GRAD_Y_WT [3][3] = '{'{1, 2, 1}, '{0, 0, 0}, '{-1, -2, -1}};

  typedef struct packed {
    logic [7:0] pixel;
    logic       last;
  } exp_px_t;

  typedef enum logic [1:0] {CHECK_PREDICT, CHECK_NONE, CHECK_GIVEN} check_src_t;
  typedef enum logic {ROW_CFG, ROW_ITEMS} row_op_t;

  typedef struct packed {
    row_op_t     op;
    logic        set_width;
    logic [10:0] width;
    logic        set_mode;
    logic [1:0]  mode;
    logic        kind;
    logic [7:0]  pixel;
    logic [5:0]  count;
    check_src_t  src;
    logic [7:0]  exp_pixel;
    logic        exp_last;
  } stim_row_t;

  // One 5x5 frame (width written as 0, acts as 5), all results known by hand
  // except where the unused mode code runs the gaussian.
  localparam stim_row_t DIRECTED [9] = '{
    // width below range, sobel x
    '{ROW_CFG, 1'b1, 11'd0, 1'b1, iwc_pkg::MODE_SOBEL_X, iwc_pkg::KIND_PIXEL, 8'd0, 6'd0,
      CHECK_NONE, 8'd0, 1'b0},
    // first 2W+2 transactions give nothing
    '{ROW_ITEMS, 1'b0, 11'd0, 1'b0, iwc_pkg::MODE_GAUSS, iwc_pkg::KIND_PIXEL, 8'd255, 6'd12,
      CHECK_NONE, 8'd0, 1'b0},
    // corner of an all-white image: 765 clamps to 255
    '{ROW_ITEMS, 1'b0, 11'd0, 1'b0, iwc_pkg::MODE_GAUSS, iwc_pkg::KIND_PIXEL, 8'd255, 6'd1,
      CHECK_GIVEN, 8'd255, 1'b0},
    // mode change mid-frame, no restart
    '{ROW_CFG, 1'b0, 11'd0, 1'b1, iwc_pkg::MODE_SOBEL_Y, iwc_pkg::KIND_PIXEL, 8'd0, 6'd0,
      CHECK_NONE, 8'd0, 1'b0},
    // top edge of white image: -1020 clamps to 0
    '{ROW_ITEMS, 1'b0, 11'd0, 1'b0, iwc_pkg::MODE_GAUSS, iwc_pkg::KIND_PIXEL, 8'd255, 6'd1,
      CHECK_GIVEN, 8'd0, 1'b0},
    '{ROW_CFG, 1'b0, 11'd0, 1'b1, MODE_UNUSED, iwc_pkg::KIND_PIXEL, 8'd0, 6'd0,
      CHECK_NONE, 8'd0, 1'b0},
    // flush inside the image reads as black, value bits ignored
    '{ROW_ITEMS, 1'b0, 11'd0, 1'b0, iwc_pkg::MODE_GAUSS, KIND_FLUSH, 8'd255, 6'd11,
      CHECK_PREDICT, 8'd0, 1'b0},
    // pixels past the end act as flush; the last one closes the frame
    '{ROW_ITEMS, 1'b0, 11'd0, 1'b0, iwc_pkg::MODE_GAUSS, iwc_pkg::KIND_PIXEL, 8'd255, 6'd12,
      CHECK_PREDICT, 8'd0, 1'b0},
    // next frame starts over at position zero
    '{ROW_ITEMS, 1'b0, 11'd0, 1'b0, iwc_pkg::MODE_GAUSS, iwc_pkg::KIND_PIXEL, 8'd0, 6'd1,
      CHECK_NONE, 8'd0, 1'b0}
  };

  logic        clk;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic        kind      = iwc_pkg::KIND_PIXEL;
  logic [7:0]  pixel_in  = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  pixel_out;
  logic        frame_last;
  logic        cfg_we    = 1'b0;
  logic        cfg_index = iwc_pkg::REG_IMAGE_WIDTH;
  logic [10:0] cfg_data  = 11'd0;

  image_window_convolution dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .pixel_in   (pixel_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_out  (pixel_out),
    .frame_last (frame_last),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: pixel history indexed by frame position, input and output
  // positions, and the shadow registers.
  // ---------------------------------------------------------------------------
  logic [7:0]  hist_px [HIST_DEPTH];
  int unsigned pred_row, pred_col, pred_out;
  logic [10:0] width_cfg = iwc_pkg::WIDTH_RESET;
  logic [1:0]  mode_cfg  = iwc_pkg::MODE_GAUSS;

  exp_px_t     filtered_q [$];      // expected output transactions, oldest first
  int          mismatches   = 0;
  int unsigned random_items = 0;
  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop well past the slowest passing run.
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int unsigned active_width();
    if (width_cfg < iwc_pkg::MIN_WIDTH) return iwc_pkg::MIN_WIDTH;
    if (width_cfg > iwc_pkg::DEF_MAX_WIDTH) return iwc_pkg::DEF_MAX_WIDTH;
    return width_cfg;
  endfunction

  // Filtered value at frame position p; taps off the image read as zero.
  function automatic logic [7:0] filter_pixel(input int unsigned w, input int unsigned p);
    int tap [5][5];
    int wi, r, c, rr, cc, i, j, acc;
    wi  = int'(w);
    r   = int'(p / w);
    c   = int'(p % w);
    acc = 0;
    for (i = 0; i < 5; i++) begin
      for (j = 0; j < 5; j++) begin
        rr = r + i - 2;
        cc = c + j - 2;
        if (rr >= 0 && cc >= 0 && rr < wi && cc < wi) begin
          tap[i][j] = int'(hist_px[(rr * wi + cc) % HIST_DEPTH]);
        end else begin
          tap[i][j] = 0;
        end
      end
    end
    if (mode_cfg == iwc_pkg::MODE_SOBEL_X || mode_cfg == iwc_pkg::MODE_SOBEL_Y) begin
      // centred 3x3, correlation, no mask flip
      for (i = 0; i < 3; i++) begin
        for (j = 0; j < 3; j++) begin
          acc += ((mode_cfg == iwc_pkg::MODE_SOBEL_X) ? GRAD_X_WT[i][j] : GRAD_Y_WT[i][j])
                 * tap[i + 1][j + 1];
        end
      end
      if (acc < 0) acc = 0;
      else if (acc > 255) acc = 255;
      return 8'(acc);
    end
    for (i = 0; i < 5; i++) begin
      for (j = 0; j < 5; j++) acc += BLUR_WT[i][j] * tap[i][j];
    end
    return 8'(acc / BLUR_NORM);
  endfunction

  // Advance the predictor by one accepted input transaction.
  function automatic void push_pixel(input logic k, input logic [7:0] v,
                                     output bit has_out, output exp_px_t res);
    int unsigned w, pos;
    w   = active_width();
    pos = pred_row * w + pred_col;
    // flush inside the image is black; pixels past the end count as flush
    hist_px[pos % HIST_DEPTH] = (k == iwc_pkg::KIND_PIXEL && pos < w * w) ? v : 8'd0;
    pred_col++;
    if (pred_col >= w) begin
      pred_col = 0;
      pred_row = (pred_row + 1) & 32'h7FF;
    end
    has_out = (pos >= 2 * w + 2);
    res     = '0;
    if (has_out) begin
      res.pixel = filter_pixel(w, pred_out);
      pred_out++;
      res.last = (pred_out >= w * w);
      if (res.last) begin
        pred_row = 0;
        pred_col = 0;
        pred_out = 0;
      end
    end
  endfunction

  function automatic void set_idling(input int unsigned done);
    if (done < RANDOM_ITEMS / 3) begin
      send_gap_pct   = 9;
      recv_stall_pct = 71;
    end else if (done < 2 * RANDOM_ITEMS / 3) begin
      send_gap_pct   = 71;
      recv_stall_pct = 9;
    end else begin
      send_gap_pct   = 0;
      recv_stall_pct = 0;
    end
  endfunction

  // Frame content: noise, a wrapping ramp (mid-range gradients), or black/white.
  function automatic logic [7:0] make_pixel(input int unsigned style, input int unsigned r,
                                            input int unsigned c);
    case (style)
      0:       return 8'($urandom_range(255));
      1:       return 8'(r * 9 + c * 5 + $urandom_range(6));
      default: return $urandom_range(1) ? 8'd255 : 8'd0;
    endcase
  endfunction

  // Sender stops until every expected transaction is out, then lets the pipe empty.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Register writes on back-to-back edges; block idle throughout.
  task automatic write_regs(input logic set_w, input logic [10:0] w,
                            input logic set_m, input logic [1:0] m);
    wait_drained();
    if (set_w) begin
      cfg_we    <= 1'b1;
      cfg_index <= iwc_pkg::REG_IMAGE_WIDTH;
      cfg_data  <= w;
      @(posedge clk);
      width_cfg = w;
      pred_row  = 0;        // width write restarts the frame
      pred_col  = 0;
      pred_out  = 0;
    end
    if (set_m) begin
      cfg_we    <= 1'b1;
      cfg_index <= iwc_pkg::REG_FILTER_MODE;
      cfg_data  <= {9'd0, m};
      @(posedge clk);
      mode_cfg = m;
    end
    cfg_we <= 1'b0;
  endtask

  // One input transaction. Valid stays up after acceptance; the next call or a
  // drain decides whether it drops, so valid gets one assignment per step.
  task automatic send_item(input logic k, input logic [7:0] v,
                           input check_src_t src, input exp_px_t given);
    bit      has_out;
    exp_px_t res;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    pixel_in <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    push_pixel(k, v, has_out, res);
    case (src)
      CHECK_PREDICT: if (has_out) filtered_q.push_back(res);
      CHECK_GIVEN:   filtered_q.push_back(given);
      default:       ;
    endcase
  endtask

  // n_items transactions of a w-wide frame from position 0; a full frame is
  // w*w image positions plus the 2w+2 drain tail.
  task automatic run_frame(input int unsigned w, input int unsigned n_items);
    int unsigned total, n, style;
    logic        k;
    logic [7:0]  v;
    total = w * w;
    style = $urandom_range(2);
    for (n = 0; n < n_items; n++) begin
      set_idling(random_items);
      if (n < total) begin
        k = ($urandom_range(99) < 3) ? KIND_FLUSH : iwc_pkg::KIND_PIXEL;
        v = make_pixel(style, n / w, n % w);
      end else begin
        k = ($urandom_range(99) < 10) ? iwc_pkg::KIND_PIXEL : KIND_FLUSH;
        v = 8'($urandom_range(255));
      end
      if ($urandom_range(399) == 0) wait_drained();
      send_item(k, v, CHECK_PREDICT, '0);
      random_items++;
    end
  endtask

  // Receiver: ready drops at random per the current idling split.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Output check: every accepted transaction against the oldest expectation.
  always @(posedge clk) begin : check_output
    exp_px_t want;
    if (!rst && out_valid && out_ready) begin
      if (filtered_q.size() == 0) begin
        $error("unexpected output transaction: pixel_out %0d frame_last %0b",
               pixel_out, frame_last);
        mismatches++;
      end else begin
        want = filtered_q.pop_front();
        if (pixel_out !== want.pixel) begin
          $error("pixel_out mismatch: expected %0d, actual %0d", want.pixel, pixel_out);
          mismatches++;
        end
        if (frame_last !== want.last) begin
          $error("frame_last mismatch: expected %0b, actual %0b", want.last, frame_last);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned i, n, nframes, f, w, span;
    logic [10:0] wval;
    int unsigned pick;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed table
    set_idling(0);
    for (i = 0; i < 9; i++) begin
      if (DIRECTED[i].op == ROW_CFG) begin
        write_regs(DIRECTED[i].set_width, DIRECTED[i].width,
                   DIRECTED[i].set_mode, DIRECTED[i].mode);
      end else begin
        for (n = 0; n < DIRECTED[i].count; n++) begin
          send_item(DIRECTED[i].kind, DIRECTED[i].pixel, DIRECTED[i].src,
                    '{DIRECTED[i].exp_pixel, DIRECTED[i].exp_last});
        end
      end
    end

    // random phases, each opened by a width write (frame restart)
    while (random_items < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 8)       wval = 11'($urandom_range(4));      // below range
      else if (pick < 70) wval = 11'($urandom_range(9, 5));
      else if (pick < 92) wval = 11'($urandom_range(16, 10));
      else                wval = 11'($urandom_range(24, 17));
      write_regs(1'b1, wval, 1'b1, 2'($urandom_range(3)));
      w       = active_width();
      span    = w * w + 2 * w + 2;
      nframes = $urandom_range(3, 1);
      for (f = 0; f < nframes && random_items < RANDOM_ITEMS; f++) begin
        // only the phase's last frame may be cut short
        if (f == nframes - 1 && $urandom_range(9) == 0) begin
          run_frame(w, $urandom_range(span - 1, 1));
        end else begin
          run_frame(w, span);
          if (f != nframes - 1 && $urandom_range(3) == 0)
            write_regs(1'b0, 11'd0, 1'b1, 2'($urandom_range(3)));
        end
      end
    end

    // widest setting, exact limit and above range; the first transactions of a
    // full-width frame give no result
    write_regs(1'b1, 11'(iwc_pkg::DEF_MAX_WIDTH), 1'b1, iwc_pkg::MODE_SOBEL_X);
    run_frame(iwc_pkg::DEF_MAX_WIDTH, WIDE_ITEMS);
    write_regs(1'b1, 11'h7FF, 1'b1, iwc_pkg::MODE_GAUSS);
    run_frame(iwc_pkg::DEF_MAX_WIDTH, WIDE_ITEMS);

    wait_drained();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: image_window_convolution.f
+incdir+design
design/iwc_pkg.sv
design/iwc_line_store.sv
design/iwc_filter.sv
design/image_window_convolution.sv
design/iwc_checker.sv
verif/image_window_convolution_tb.sv
